// ===== sv/kld_pkg.sv =====
// shared types, constants and the leading-one helper of the divergence accumulator
// no dependencies
package kld_pkg;

  localparam int LnFracBits = 24;
  localparam int LogWidth   = 5 + LnFracBits;
  localparam logic [31:0] Ln2Q32 = 32'hB172_17F8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISSING  = 2'd1;
  localparam logic [1:0] ST_INFINITE = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // one squaring cell of the log2 chain
  typedef struct packed {
    logic        vld;
    logic [31:0] x;
    logic [31:0] y;
    logic        xm;
    logic        ym;
    logic        last;
    logic [31:0] mx;
    logic [31:0] my;
    logic [4:0]  ex;
    logic [4:0]  ey;
    logic [LnFracBits-1:0] fx;
    logic [LnFracBits-1:0] fy;
  } kld_cell_t;

  function automatic logic [4:0] kld_msb(input logic [31:0] v);
    logic [4:0] e;
    e = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        e = 5'(i);
      end
    end
    return e;
  endfunction

endpackage

// ===== sv/kld_cell.sv =====
// one squaring step for the log2 fractions of both operands
// depends on kld_pkg
module kld_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  kld_pkg::kld_cell_t cell_in,
  output kld_pkg::kld_cell_t cell_out
);
  import kld_pkg::*;

  kld_cell_t  cell_r;
  kld_cell_t  cell_nxt;
  logic [63:0] sqx;
  logic [63:0] sqy;

  always_comb begin
    sqx = 64'(cell_in.mx) * 64'(cell_in.mx);
    sqy = 64'(cell_in.my) * 64'(cell_in.my);
    cell_nxt = cell_in;
    cell_nxt.fx = {cell_in.fx[LnFracBits-2:0], sqx[63]};
    cell_nxt.fy = {cell_in.fy[LnFracBits-2:0], sqy[63]};
    cell_nxt.mx = sqx[63] ? sqx[63:32] : sqx[62:31];
    cell_nxt.my = sqy[63] ? sqy[63:32] : sqy[62:31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else begin
      cell_r.vld <= cell_nxt.vld;
    end
    cell_r.x    <= cell_nxt.x;
    cell_r.y    <= cell_nxt.y;
    cell_r.xm   <= cell_nxt.xm;
    cell_r.ym   <= cell_nxt.ym;
    cell_r.last <= cell_nxt.last;
    cell_r.mx   <= cell_nxt.mx;
    cell_r.my   <= cell_nxt.my;
    cell_r.ex   <= cell_nxt.ex;
    cell_r.ey   <= cell_nxt.ey;
    cell_r.fx   <= cell_nxt.fx;
    cell_r.fy   <= cell_nxt.fy;
  end

  assign cell_out = cell_r;

endmodule

// ===== sv/kld_accum.sv =====
// term arithmetic, clamping and the running sum with status
// depends on kld_pkg
module kld_accum (
  input  logic               clk,
  input  logic               rst_n,
  input  kld_pkg::kld_cell_t cell_in,
  output logic               res_vld,
  output logic [63:0]        res_total,
  output logic [1:0]         res_status
);
  import kld_pkg::*;

  // stage a: log difference times ln2
  logic              a_vld_r;
  logic [31:0]       a_x_r, a_y_r;
  logic              a_xm_r, a_ym_r, a_last_r, a_pos_r;
  logic [63:0]       a_ln_r;
  // stage b: x times ln magnitude
  logic              b_vld_r;
  logic [31:0]       b_x_r, b_y_r;
  logic              b_xm_r, b_ym_r, b_last_r, b_pos_r;
  logic [63:0]       b_pa_r, b_pb_r;

  logic [LogWidth-1:0] lx, ly, dm;
  logic              pos;
  logic [95:0]       ln_prod;
  logic [63:0]       ln_nxt;
  logic [63:0]       xl;
  logic signed [65:0] st;
  logic [63:0]       term;
  logic [64:0]       sum;
  logic [63:0]       sum_r, sum_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic              res_vld_r;
  logic [63:0]       res_total_r;
  logic [1:0]        res_status_r;

  always_comb begin
    lx  = {cell_in.ex, cell_in.fx};
    ly  = {cell_in.ey, cell_in.fy};
    pos = lx >= ly;
    dm  = pos ? lx - ly : ly - lx;
    ln_prod = 96'(dm) * 96'(Ln2Q32);
    ln_nxt  = ln_prod[95:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= cell_in.vld;
      b_vld_r <= a_vld_r;
    end
    a_x_r <= cell_in.x;  a_y_r <= cell_in.y;
    a_xm_r <= cell_in.xm; a_ym_r <= cell_in.ym;
    a_last_r <= cell_in.last; a_pos_r <= pos;
    a_ln_r <= ln_nxt;
    b_x_r <= a_x_r;  b_y_r <= a_y_r;
    b_xm_r <= a_xm_r; b_ym_r <= a_ym_r;
    b_last_r <= a_last_r; b_pos_r <= a_pos_r;
    b_pa_r <= 64'(a_x_r) * 64'(a_ln_r[63:32]);
    b_pb_r <= 64'(a_x_r) * 64'(a_ln_r[31:0]);
  end

  always_comb begin
    if (LnFracBits >= 16) begin
      xl = (b_pa_r << (48 - LnFracBits)) + (b_pb_r >> (LnFracBits - 16));
    end else begin
      xl = (b_pa_r << (48 - LnFracBits)) + (b_pb_r << (16 - LnFracBits));
    end
    st = (b_pos_r ? $signed({2'b00, xl}) : -$signed({2'b00, xl}))
         - $signed({18'd0, b_x_r, 16'd0}) + $signed({18'd0, b_y_r, 16'd0});
    st = $signed({{2{st[63]}}, st[63:0]});
    if (b_x_r == 32'd0) begin
      term = {16'd0, b_y_r, 16'd0};
    end else if (st[63]) begin
      term = 64'd0;
    end else begin
      term = st[63:0];
    end
    sum = 65'(sum_r) + 65'(term);
    sum_nxt  = sum_r;
    stat_nxt = stat_r;
    if (stat_r == ST_OK) begin
      if (b_xm_r || b_ym_r) begin
        stat_nxt = ST_MISSING;
      end else if (b_x_r != 32'd0 && b_y_r == 32'd0) begin
        stat_nxt = ST_INFINITE;
      end else if (sum[64]) begin
        sum_nxt  = '1;
        stat_nxt = ST_OVERFLOW;
      end else begin
        sum_nxt = sum[63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      stat_r    <= ST_OK;
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= b_vld_r && b_last_r;
      if (b_vld_r) begin
        if (b_last_r) begin
          sum_r  <= '0;
          stat_r <= ST_OK;
        end else begin
          sum_r  <= sum_nxt;
          stat_r <= stat_nxt;
        end
      end
    end
    res_total_r  <= (stat_nxt == ST_OK || stat_nxt == ST_OVERFLOW) ? sum_nxt : 64'd0;
    res_status_r <= stat_nxt;
  end

  assign res_vld    = res_vld_r;
  assign res_total  = res_total_r;
  assign res_status = res_status_r;

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    stat_r == ST_OVERFLOW |-> sum_r == '1) else $error("overflow without saturation");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r && b_last_r |=> sum_r == '0 && stat_r == ST_OK) else $error("no clear after last");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r && (res_status_r == ST_MISSING || res_status_r == ST_INFINITE)
      |-> res_total_r == '0) else $error("error total not zero");

endmodule

// ===== sv/kl_divergence_accumulator.sv =====
// divergence accumulator top level: front end, chain of squaring cells, accumulator
// a result passes the squaring chain, accumulator stages a and b, then the result and output registers;
// one request at a time: a non-last request frees the input once it leaves the squaring chain,
// a last one once its result has been taken
// reset: synchronous, active low; clears the sum, status and all valid flags
// depends on kld_pkg, kld_cell, kld_accum
module kl_divergence_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_x_value,
  input  logic [31:0] in_y_value,
  input  logic        in_x_missing,
  input  logic        in_y_missing,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_total,
  output logic [1:0]  out_status
);
  import kld_pkg::*;

  kld_cell_t   chain [LnFracBits+1];
  kld_cell_t   head;
  logic        busy_r, busy_nxt;
  logic        res_vld;
  logic [63:0] res_total;
  logic [1:0]  res_status;
  logic        ov_r, ov_nxt;
  logic [63:0] tot_r;
  logic [1:0]  st_r;
  logic [4:0]  exv, eyv;
  logic        acc;

  assign acc      = in_valid && in_ready;
  assign in_ready = !busy_r && !ov_r;

  always_comb begin
    exv = kld_msb(in_x_value);
    eyv = kld_msb(in_y_value);
    head.vld  = acc;
    head.x    = in_x_value;
    head.y    = in_y_value;
    head.xm   = in_x_missing;
    head.ym   = in_y_missing;
    head.last = in_is_last;
    head.ex   = exv;
    head.ey   = eyv;
    head.mx   = in_x_value << (5'd31 - exv);
    head.my   = in_y_value << (5'd31 - eyv);
    head.fx   = '0;
    head.fy   = '0;
  end

  assign chain[0] = head;

  for (genvar g = 0; g < LnFracBits; g++) begin : g_cell
    kld_cell u_cell (.clk(clk), .rst_n(rst_n), .cell_in(chain[g]), .cell_out(chain[g+1]));
  end

  kld_accum u_accum (
    .clk(clk), .rst_n(rst_n), .cell_in(chain[LnFracBits]),
    .res_vld(res_vld), .res_total(res_total), .res_status(res_status)
  );

  always_comb begin
    busy_nxt = busy_r;
    if (acc) begin
      busy_nxt = 1'b1;
    end else if (res_vld || (chain[LnFracBits].vld && !chain[LnFracBits].last)) begin
      busy_nxt = 1'b0;
    end
    ov_nxt = ov_r;
    if (res_vld) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  // non-last requests release after the chain; last ones after the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    if (res_vld) begin
      tot_r <= res_total;
      st_r  <= res_status;
    end
  end

  assign out_valid  = ov_r;
  assign out_total  = tot_r;
  assign out_status = st_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_ready) else $error("second request while busy");
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> !ov_r) else $error("result overwrites pending output");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_total)) else $error("output dropped");

endmodule
